// ===== hdl/vrt_pkg.sv =====
package vrt_pkg;

    // grid geometry and fixed-point format
    localparam int GRID_BITS = 4;
    localparam int GRID_SIZE = 1 << GRID_BITS;
    localparam int FRAC_BITS = 8;
    localparam int ADDR_BITS = 3 * GRID_BITS;
    localparam int DEPTH     = GRID_SIZE * GRID_SIZE * GRID_SIZE;

    // reciprocal: 2^(14+F) / |d|, one quotient bit per cycle
    localparam int QUO_BITS  = 15 + FRAC_BITS;
    localparam int REM_BITS  = 17;
    localparam int DIST_BITS = 18;
    localparam int POS_BITS  = GRID_BITS + 2;

    localparam logic [15:0] MAX_DIST_RESET = 16'd1280;
    localparam logic [DIST_BITS-1:0] FAR_AWAY = '1;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    // axis codes, AXIS_NONE marks no step taken yet
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_CHECK = 7'b0010000,
        S_READ  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

endpackage

// ===== hdl/voxel_ray_traversal.sv =====
// Voxel ray traversal. A write transaction stores one voxel type and returns an
// all-zero result in the next cycle. A cast transaction first forms the three axis
// reciprocals in one shared restoring divider, each non-zero axis followed by a
// multiply step for its first crossing, then walks the grid one voxel at a time
// (one registered read of the voxel store, then one step). in_ready is low while
// a cast is busy. After reset the store is cleared to air, one entry per cycle,
// through all 4096 entries, during which no transaction is accepted;
// configuration writes are taken at any time.
module voxel_ray_traversal
    import vrt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic [3:0]         voxel_x,
    input  logic [3:0]         voxel_y,
    input  logic [3:0]         voxel_z,
    input  logic [7:0]         block_type,
    input  logic [11:0]        origin_x,
    input  logic [11:0]        origin_y,
    input  logic [11:0]        origin_z,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic signed [15:0] dir_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit_flag,
    output logic [3:0]         hit_x,
    output logic [3:0]         hit_y,
    output logic [3:0]         hit_z,
    output logic [7:0]         hit_type,
    output logic [15:0]        hit_distance,
    output logic signed [1:0]  normal_x,
    output logic signed [1:0]  normal_y,
    output logic signed [1:0]  normal_z
);

    state_t state_reg, state_next;
    logic [ADDR_BITS-1:0] clr_reg, clr_next;
    logic [15:0] maxd_reg, maxd_next;
    logic [1:0] axis_reg, axis_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [REM_BITS-1:0] rem_reg, rem_next;
    logic [QUO_BITS-1:0] quo_reg, quo_next;
    logic [FRAC_BITS-1:0] frac_reg [3];
    logic [FRAC_BITS-1:0] frac_next [3];
    logic [15:0] mag_reg [3];
    logic [15:0] mag_next [3];
    logic [2:0] neg_reg, neg_next, nz_reg, nz_next;
    logic [15:0] td_reg [3];
    logic [15:0] td_next [3];
    logic [DIST_BITS-1:0] dist_reg [3];
    logic [DIST_BITS-1:0] dist_next [3];
    logic signed [POS_BITS-1:0] pos_reg [3];
    logic signed [POS_BITS-1:0] pos_next [3];
    logic [DIST_BITS-1:0] total_reg, total_next;
    logic [1:0] last_reg, last_next;
    logic hit_reg, hit_next;
    logic [7:0] type_reg, type_next;

    logic out_valid_reg, out_valid_next;
    logic hit_flag_reg, hit_flag_next;
    logic [3:0] hx_reg, hx_next, hy_reg, hy_next, hz_reg, hz_next;
    logic [7:0] ht_reg, ht_next;
    logic [15:0] hd_reg, hd_next;
    logic [1:0] nx_reg, nx_next, ny_reg, ny_next, nz_o_reg, nz_o_next;

    logic mem_we;
    logic [ADDR_BITS-1:0] mem_waddr, mem_raddr;
    logic [7:0] mem_wdata, rd_data_reg;
    logic [7:0] mem [DEPTH];

    // combinational helpers
    logic in_fire;
    logic [REM_BITS-1:0] rem_sh;
    logic rem_ge;
    logic [15:0] td_sat;
    logic [FRAC_BITS:0] span;
    logic [FRAC_BITS+16:0] prod;
    logic [1:0] ax;
    logic [1:0] normal_code;
    logic in_grid;
    logic [11:0] org [3];
    logic signed [15:0] dir [3];

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign org[0] = origin_x;
    assign org[1] = origin_y;
    assign org[2] = origin_z;
    assign dir[0] = dir_x;
    assign dir[1] = dir_y;
    assign dir[2] = dir_z;

    // divider step: shift in next dividend bit (only the top one is set)
    assign rem_sh = {rem_reg[REM_BITS-2:0], (cnt_reg == 5'd0)};
    assign rem_ge = rem_sh >= {1'b0, mag_reg[axis_reg]};

    // saturated reciprocal and first crossing
    assign td_sat = (quo_reg > QUO_BITS'(16'hFFFF)) ? 16'hFFFF : quo_reg[15:0];
    assign span = neg_reg[axis_reg] ? {1'b0, frac_reg[axis_reg]}
                                    : ((FRAC_BITS+1)'(1 << FRAC_BITS) -
                                       {1'b0, frac_reg[axis_reg]});
    assign prod = span * td_sat;

    // axis selection, ties resolve toward the later axis: z over y, y over x
    always_comb
    begin
        if (dist_reg[0] < dist_reg[1] && dist_reg[0] < dist_reg[2])
            ax = AXIS_X;
        else if (dist_reg[1] < dist_reg[2])
            ax = AXIS_Y;
        else
            ax = AXIS_Z;
    end

    assign in_grid = (pos_reg[0][POS_BITS-1:GRID_BITS] == '0) &&
                     (pos_reg[1][POS_BITS-1:GRID_BITS] == '0) &&
                     (pos_reg[2][POS_BITS-1:GRID_BITS] == '0);
    assign mem_raddr = {pos_reg[2][GRID_BITS-1:0], pos_reg[1][GRID_BITS-1:0],
                        pos_reg[0][GRID_BITS-1:0]};
    // normal is opposite of the step: +1 step gives -1
    assign normal_code = (last_reg != AXIS_NONE && neg_reg[last_reg]) ? 2'b01 : 2'b11;

    // sequencer and datapath next state
    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        maxd_next = maxd_reg;
        axis_next = axis_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        frac_next = frac_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        nz_next = nz_reg;
        td_next = td_reg;
        dist_next = dist_reg;
        pos_next = pos_reg;
        total_next = total_reg;
        last_next = last_reg;
        hit_next = hit_reg;
        type_next = type_reg;
        out_valid_next = out_valid_reg && !out_ready;
        hit_flag_next = hit_flag_reg;
        hx_next = hx_reg;
        hy_next = hy_reg;
        hz_next = hz_reg;
        ht_next = ht_reg;
        hd_next = hd_reg;
        nx_next = nx_reg;
        ny_next = ny_reg;
        nz_o_next = nz_o_reg;
        mem_we = 1'b0;
        mem_waddr = {voxel_z, voxel_y, voxel_x};
        mem_wdata = block_type;

        if (cfg_valid)
            maxd_next = cfg_data;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 8'd0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_BITS'(DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (op == OP_WRITE)
                    begin
                        mem_we = 1'b1;
                        out_valid_next = 1'b1;
                        hit_flag_next = 1'b0;
                        hx_next = '0;
                        hy_next = '0;
                        hz_next = '0;
                        ht_next = '0;
                        hd_next = '0;
                        nx_next = '0;
                        ny_next = '0;
                        nz_o_next = '0;
                    end
                    else
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            frac_next[a] = org[a][FRAC_BITS-1:0];
                            pos_next[a] = POS_BITS'(org[a][11:FRAC_BITS]);
                            neg_next[a] = dir[a][15];
                            nz_next[a] = (dir[a] != 16'sd0);
                            mag_next[a] = dir[a][15] ? 16'(-dir[a]) : dir[a];
                        end
                        axis_next = AXIS_X;
                        cnt_next = '0;
                        rem_next = '0;
                        total_next = '0;
                        last_next = AXIS_NONE;
                        hit_next = 1'b0;
                        type_next = '0;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (!nz_reg[axis_reg])
                begin
                    dist_next[axis_reg] = FAR_AWAY;
                    td_next[axis_reg] = '0;
                    if (axis_reg == AXIS_Z)
                        state_next = (nz_reg == 3'b000) ? S_DONE : S_CHECK;
                    else
                        axis_next = axis_reg + 1'b1;
                end
                else
                begin
                    rem_next = rem_ge ? rem_sh - {1'b0, mag_reg[axis_reg]} : rem_sh;
                    quo_next = {quo_reg[QUO_BITS-2:0], rem_ge};
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == 5'(QUO_BITS - 1))
                        state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                td_next[axis_reg] = td_sat;
                dist_next[axis_reg] = DIST_BITS'(prod[FRAC_BITS+16:FRAC_BITS]);
                cnt_next = '0;
                rem_next = '0;
                if (axis_reg == AXIS_Z)
                    state_next = S_CHECK;
                else
                begin
                    axis_next = axis_reg + 1'b1;
                    state_next = S_DIV;
                end
            end
            S_CHECK:
            begin
                if (total_reg >= DIST_BITS'(maxd_reg) || !in_grid)
                    state_next = S_DONE;
                else
                    state_next = S_READ;
            end
            S_READ:
            begin
                if (rd_data_reg != 8'd0)
                begin
                    hit_next = 1'b1;
                    type_next = rd_data_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    total_next = dist_reg[ax];
                    dist_next[ax] = dist_reg[ax] + DIST_BITS'(td_reg[ax]);
                    pos_next[ax] = neg_reg[ax] ? pos_reg[ax] - POS_BITS'(1)
                                               : pos_reg[ax] + POS_BITS'(1);
                    last_next = ax;
                    state_next = S_CHECK;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    hit_flag_next = hit_reg;
                    hx_next = hit_reg ? pos_reg[0][GRID_BITS-1:0] : '0;
                    hy_next = hit_reg ? pos_reg[1][GRID_BITS-1:0] : '0;
                    hz_next = hit_reg ? pos_reg[2][GRID_BITS-1:0] : '0;
                    ht_next = hit_reg ? type_reg : '0;
                    hd_next = !hit_reg ? 16'd0 :
                              (total_reg > DIST_BITS'(16'hFFFF)) ? 16'hFFFF
                                                                 : total_reg[15:0];
                    nx_next = (hit_reg && last_reg == AXIS_X) ? normal_code : 2'b00;
                    ny_next = (hit_reg && last_reg == AXIS_Y) ? normal_code : 2'b00;
                    nz_o_next = (hit_reg && last_reg == AXIS_Z) ? normal_code : 2'b00;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            maxd_reg <= MAX_DIST_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            maxd_reg <= maxd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        axis_reg <= axis_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        frac_reg <= frac_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        nz_reg <= nz_next;
        td_reg <= td_next;
        dist_reg <= dist_next;
        pos_reg <= pos_next;
        total_reg <= total_next;
        last_reg <= last_next;
        hit_reg <= hit_next;
        type_reg <= type_next;
        hit_flag_reg <= hit_flag_next;
        hx_reg <= hx_next;
        hy_reg <= hy_next;
        hz_reg <= hz_next;
        ht_reg <= ht_next;
        hd_reg <= hd_next;
        nx_reg <= nx_next;
        ny_reg <= ny_next;
        nz_o_reg <= nz_o_next;
    end

    // voxel store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    assign out_valid    = out_valid_reg;
    assign hit_flag     = hit_flag_reg;
    assign hit_x        = hx_reg;
    assign hit_y        = hy_reg;
    assign hit_z        = hz_reg;
    assign hit_type     = ht_reg;
    assign hit_distance = hd_reg;
    assign normal_x     = nx_reg;
    assign normal_y     = ny_reg;
    assign normal_z     = nz_o_reg;

endmodule

// ===== hdl/voxel_ray_traversal_checker.sv =====
module voxel_ray_traversal_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              hit_flag,
    input logic [7:0]        hit_type,
    input logic [15:0]       hit_distance,
    input logic signed [1:0] normal_x,
    input logic signed [1:0] normal_y,
    input logic signed [1:0] normal_z
);

    // a result waits until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transaction");

    // no new transaction while a result is stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken over a stalled result");

    // a hit always carries a solid type
    a_hit_type: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit_flag |-> hit_type != 8'd0)
        else $error("hit reported on air");

    // a miss or write result has zero type, distance and normals
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit_flag |-> hit_type == 8'd0 && hit_distance == 16'd0 &&
        normal_x == 2'sd0 && normal_y == 2'sd0 && normal_z == 2'sd0)
        else $error("miss result not cleared");

    // at most one normal axis is set
    a_one_normal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones({normal_x != 2'sd0, normal_y != 2'sd0,
                                  normal_z != 2'sd0}) <= 1)
        else $error("more than one normal axis set");

endmodule

bind voxel_ray_traversal voxel_ray_traversal_checker u_checker
(
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hit_flag(hit_flag),
    .hit_type(hit_type),
    .hit_distance(hit_distance),
    .normal_x(normal_x),
    .normal_y(normal_y),
    .normal_z(normal_z)
);

// ===== sim/voxel_ray_traversal_test.sv =====
`timescale 1ns / 1ps

module voxel_ray_traversal_test;
    import vrt_pkg::*;

    typedef struct packed {
        logic              hit;
        logic [3:0]        hx;
        logic [3:0]        hy;
        logic [3:0]        hz;
        logic [7:0]        htype;
        logic [15:0]       hdist;
        logic signed [1:0] nx;
        logic signed [1:0] ny;
        logic signed [1:0] nz;
    } ray_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               op;
    logic [3:0]         voxel_x;
    logic [3:0]         voxel_y;
    logic [3:0]         voxel_z;
    logic [7:0]         block_type;
    logic [11:0]        origin_x;
    logic [11:0]        origin_y;
    logic [11:0]        origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic               out_valid;
    logic               out_ready;
    logic               hit_flag;
    logic [3:0]         hit_x;
    logic [3:0]         hit_y;
    logic [3:0]         hit_z;
    logic [7:0]         hit_type;
    logic [15:0]        hit_distance;
    logic signed [1:0]  normal_x;
    logic signed [1:0]  normal_y;
    logic signed [1:0]  normal_z;

    // predictor state
    logic [7:0]  world [DEPTH];
    logic [15:0] ray_limit;
    ray_result_t expected_hits[$];

    int  errors;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_cycles;

    voxel_ray_traversal i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .voxel_x      (voxel_x),
        .voxel_y      (voxel_y),
        .voxel_z      (voxel_z),
        .block_type   (block_type),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .origin_z     (origin_z),
        .dir_x        (dir_x),
        .dir_y        (dir_y),
        .dir_z        (dir_z),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit_flag     (hit_flag),
        .hit_x        (hit_x),
        .hit_y        (hit_y),
        .hit_z        (hit_z),
        .hit_type     (hit_type),
        .hit_distance (hit_distance),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .normal_z     (normal_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // DDA walk of one ray through the predicted world
    function automatic ray_result_t trace_ray(logic [11:0] org [3], logic signed [15:0] dv [3]);
        ray_result_t r;
        int          p [3];
        int          stp [3];
        longint      td [3];
        longint      dd [3];
        longint      walked;
        longint      span;
        longint      mag;
        int          last;
        int          ax;
        logic [7:0]  t;
        r = '0;
        walked = 0;
        last = -1;
        for (int a = 0; a < 3; a++)
        begin
            p[a] = int'(org[a] >> FRAC_BITS);
            if (dv[a] == 0)
            begin
                stp[a] = 0;
                td[a] = 0;
                dd[a] = 64'hFFFF_FFFF;
            end
            else
            begin
                mag = (dv[a] < 0) ? -longint'(dv[a]) : longint'(dv[a]);
                td[a] = (longint'(1) << (14 + FRAC_BITS)) / mag;
                if (td[a] > 65535)
                    td[a] = 65535;
                stp[a] = (dv[a] < 0) ? -1 : 1;
                span = (dv[a] < 0) ? longint'(org[a][7:0]) : 256 - longint'(org[a][7:0]);
                dd[a] = (span * td[a]) >> FRAC_BITS;
            end
        end
        if (stp[0] == 0 && stp[1] == 0 && stp[2] == 0)
            return r;
        while (walked < ray_limit)
        begin
            if (p[0] < 0 || p[0] >= GRID_SIZE || p[1] < 0 || p[1] >= GRID_SIZE
                || p[2] < 0 || p[2] >= GRID_SIZE)
                return r;
            t = world[p[0] + GRID_SIZE * (p[1] + GRID_SIZE * p[2])];
            if (t != 0)
            begin
                r.hit = 1'b1;
                r.hx = p[0][3:0];
                r.hy = p[1][3:0];
                r.hz = p[2][3:0];
                r.htype = t;
                r.hdist = (walked > 65535) ? 16'hFFFF : walked[15:0];
                if (last == 0) r.nx = 2'(-stp[0]);
                if (last == 1) r.ny = 2'(-stp[1]);
                if (last == 2) r.nz = 2'(-stp[2]);
                return r;
            end
            if (dd[0] < dd[1] && dd[0] < dd[2])
                ax = 0;
            else if (dd[1] < dd[2])
                ax = 1;
            else
                ax = 2;
            walked = dd[ax];
            dd[ax] += td[ax];
            p[ax] += stp[ax];
            last = ax;
        end
        return r;
    endfunction

    // send one transaction and queue its prediction
    task automatic send_item(logic o, logic [3:0] vx, logic [3:0] vy, logic [3:0] vz,
                             logic [7:0] bt, logic [11:0] ox, logic [11:0] oy,
                             logic [11:0] oz, logic signed [15:0] dx,
                             logic signed [15:0] dy, logic signed [15:0] dz);
        logic [11:0]        org [3];
        logic signed [15:0] dv [3];
        // valid drops only when the sender idles; drain clears it at the end
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= o;
        voxel_x    <= vx;
        voxel_y    <= vy;
        voxel_z    <= vz;
        block_type <= bt;
        origin_x   <= ox;
        origin_y   <= oy;
        origin_z   <= oz;
        dir_x      <= dx;
        dir_y      <= dy;
        dir_z      <= dz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (o == OP_WRITE)
        begin
            world[vx + GRID_SIZE * (vy + GRID_SIZE * vz)] = bt;
            expected_hits.push_back('0);
        end
        else
        begin
            org = '{ox, oy, oz};
            dv = '{dx, dy, dz};
            expected_hits.push_back(trace_ray(org, dv));
        end
    endtask

    task automatic write_voxel(int x, int y, int z, int t);
        send_item(OP_WRITE, 4'(x), 4'(y), 4'(z), 8'(t), 12'd0, 12'd0, 12'd0,
                  16'sd0, 16'sd0, 16'sd0);
    endtask

    task automatic cast_ray(int ox, int oy, int oz, int dx, int dy, int dz);
        send_item(OP_CAST, 4'($urandom), 4'($urandom), 4'($urandom), 8'($urandom),
                  12'(ox), 12'(oy), 12'(oz), 16'(dx), 16'(dy), 16'(dz));
    endtask

    function automatic int rand_dir();
        int k;
        k = $urandom_range(9);
        if (k == 0) return 0;
        if (k == 1) return $urandom_range(1) ? 16384 : -16384;
        if (k == 2) return $urandom_range(1) ? 32767 : -32768;
        if (k == 3) return $urandom_range(1) ? $urandom_range(1, 40) : -$urandom_range(1, 40);
        return $urandom_range(32768) - 16384;
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic set_limit(logic [15:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        ray_limit = v;
    endtask

    // directed: extremes, writes outside usual range, special cases
    task automatic test_directed();
        write_voxel(0, 0, 0, 255);
        write_voxel(15, 15, 15, 1);
        write_voxel(5, 8, 8, 7);
        write_voxel(8, 5, 8, 9);
        cast_ray(12'h880, 12'h880, 12'h880, 0, 0, 0);        // zero direction
        cast_ray(12'h080, 12'h080, 12'h080, 16384, 0, 0);    // hit in origin voxel
        cast_ray(12'hF80, 12'h880, 12'h880, -16384, 0, 0);   // x ray, stopped by distance limit
        cast_ray(12'h880, 12'hF80, 12'h880, 0, -16384, 0);   // y ray, stopped by distance limit
        cast_ray(12'h880, 12'h880, 12'h080, 0, 0, 16384);    // stopped by distance limit
        cast_ray(12'hEFF, 12'hEFF, 12'hEFF, 32767, 32767, 32767);
        cast_ray(12'h100, 12'h100, 12'h100, -32768, -32768, -32768);
        cast_ray(12'h880, 12'h880, 12'h880, 1, -1, 0);       // tiny direction
        cast_ray(12'hFFF, 12'h000, 12'h800, -5000, 7000, -3);
        write_voxel(0, 0, 0, 0);
        cast_ray(12'h0FF, 12'h0FF, 12'h0FF, -16384, 0, 0);
        set_limit(16'd0);
        cast_ray(12'h080, 12'h080, 12'h080, 0, 16384, 0);    // zero limit misses
        cast_ray(12'hF80, 12'hF80, 12'hF80, 16384, 16384, 16384);
        set_limit(16'hFFFF);
        cast_ray(12'h880, 12'h880, 12'h880, 16384, 0, 0);
        cast_ray(12'hF80, 12'hF80, 12'hF80, -3, -2, -1);
        cast_ray(12'h080, 12'h080, 12'h080, 1, 1, 1);
    endtask

    // random scene building plus casts aimed into the grid
    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 30)
                send_item(OP_WRITE, 4'($urandom), 4'($urandom), 4'($urandom),
                          8'($urandom_range(3) == 0 ? 0 : $urandom_range(255)),
                          12'($urandom), 12'($urandom), 12'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom));
            else
                cast_ray($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                         rand_dir(), rand_dir(), rand_dir());
        end
    endtask

    // receiver stalls long while the sender keeps offering
    task automatic test_backpressure();
        hold_cycles = 300;
        cast_ray(12'h880, 12'h880, 12'h880, 16384, 0, 0);
        test_random(6);
        in_valid <= 1'b0;
        while (hold_cycles != 0)
            @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        ray_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_hits.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
            end
            else
            begin
                e = expected_hits.pop_front();
                if (hit_flag !== e.hit)
                begin $error("hit_flag exp %0d got %0d", e.hit, hit_flag); errors++; end
                if (hit_x !== e.hx)
                begin $error("hit_x exp %0d got %0d", e.hx, hit_x); errors++; end
                if (hit_y !== e.hy)
                begin $error("hit_y exp %0d got %0d", e.hy, hit_y); errors++; end
                if (hit_z !== e.hz)
                begin $error("hit_z exp %0d got %0d", e.hz, hit_z); errors++; end
                if (hit_type !== e.htype)
                begin $error("hit_type exp %0d got %0d", e.htype, hit_type); errors++; end
                if (hit_distance !== e.hdist)
                begin
                    $error("hit_distance exp %0d got %0d", e.hdist, hit_distance);
                    errors++;
                end
                if (normal_x !== e.nx)
                begin $error("normal_x exp %0d got %0d", e.nx, normal_x); errors++; end
                if (normal_y !== e.ny)
                begin $error("normal_y exp %0d got %0d", e.ny, normal_y); errors++; end
                if (normal_z !== e.nz)
                begin $error("normal_z exp %0d got %0d", e.nz, normal_z); errors++; end
            end
        end
    end

    // receiver ready, with optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_cycles != 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        #20_000_000;
        $display("** voxel_ray_traversal: FAILED **");
        $finish;
    end

    initial
    begin
        errors = 0;
        hold_cycles = 0;
        send_idle_pct = 9;
        recv_idle_pct = 52;
        ray_limit = MAX_DIST_RESET;
        foreach (world[i]) world[i] = 8'd0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        op = OP_WRITE;
        voxel_x = '0; voxel_y = '0; voxel_z = '0;
        block_type = '0;
        origin_x = '0; origin_y = '0; origin_z = '0;
        dir_x = '0; dir_y = '0; dir_z = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        set_limit(MAX_DIST_RESET);
        test_random(330);
        test_backpressure();
        send_idle_pct = 52;
        recv_idle_pct = 9;
        set_limit(16'd300);
        test_random(330);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_limit(16'd4000);
        test_random(330);
        drain();

        if (errors == 0)
            $display("** voxel_ray_traversal: PASSED **");
        else
            $display("** voxel_ray_traversal: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/vrt_pkg.sv
hdl/voxel_ray_traversal.sv
hdl/voxel_ray_traversal_checker.sv
sim/voxel_ray_traversal_test.sv
